// ----- hw/rtl/bbd_pkg.sv -----
// ============================================================================
// bbd_pkg: shared types, constants and arithmetic helpers
// Register map, operation codes, the front-to-back job record and the
// zero-aware averaging functions of the bilinear Bayer demosaic.
// ============================================================================
`default_nettype none

package bbd_pkg;

  // Line store size.
  localparam int unsigned MaxWidthDefault = 1024;

  // Configuration registers.
  localparam int unsigned WidthRegW  = 11;
  localparam int unsigned HeightRegW = 13;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 13;

  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam logic [WidthRegW-1:0]  WidthReset  = 11'd640;
  localparam logic [HeightRegW-1:0] HeightReset = 13'd480;
  localparam logic [HeightRegW-1:0] HeightMax   = 13'd4096;

  // The row counter must be able to hold the height itself.
  localparam int unsigned RowCntW = 13;

  // Input operation codes.
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Job queue between front and back.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef logic [7:0] sample_t;

  // One accepted item that produces output: the masked 3x3 strip after the
  // shift, indexed [row][column], plus what the back needs to expand it into
  // one or two pixels.
  typedef struct packed {
    sample_t [2:0][2:0] strip;
    logic               has_first;
    logic               has_tail;
    logic               col_lsb;
    logic               row_lsb;
    logic               end_of_frame;
  } job_t;

  typedef struct packed {
    sample_t red;
    sample_t green;
    sample_t blue;
    logic    last_of_run;
    logic    end_of_frame;
  } pixel_t;

  // Floor average of two samples, counting only nonzero ones.
  function automatic sample_t avg2(input sample_t a, input sample_t b);
    logic [8:0] sum;
    sample_t    res;
    sum = 9'(a) + 9'(b);
    if ((a != 8'd0) && (b != 8'd0)) begin
      res = sum[8:1];
    end else begin
      res = sum[7:0];
    end
    return res;
  endfunction

  // Floor average of four samples, counting only nonzero ones. The divide
  // by three is a multiply by 683/2048, exact for sums below 2046.
  function automatic sample_t avg4(input sample_t a, input sample_t b,
                                   input sample_t c, input sample_t d);
    logic [9:0]  sum;
    logic [2:0]  cnt;
    logic [19:0] prod;
    sample_t     res;
    sum  = 10'(a) + 10'(b) + 10'(c) + 10'(d);
    cnt  = 3'(a != 8'd0) + 3'(b != 8'd0) + 3'(c != 8'd0) + 3'(d != 8'd0);
    prod = 20'(sum) * 20'd683;
    case (cnt)
      3'd1:    res = sum[7:0];
      3'd2:    res = sum[8:1];
      3'd3:    res = prod[18:11];
      3'd4:    res = sum[9:2];
      default: res = 8'd0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bbd_intf.sv -----
// ============================================================================
// bbd_intf: stream and configuration channels
// Valid/ready channels for raw samples, reconstructed pixels and register
// writes.
// ============================================================================
`default_nettype none

interface bbd_in_if import bbd_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    operation;
  sample_t pixel_value;

  modport source (output valid, output operation, output pixel_value, input ready);
  modport sink   (input valid, input operation, input pixel_value, output ready);
endinterface

interface bbd_out_if import bbd_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t red;
  sample_t green;
  sample_t blue;
  logic    last_of_run;
  logic    end_of_frame;

  modport source (output valid, output red, output green, output blue,
                  output last_of_run, output end_of_frame, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input last_of_run, input end_of_frame, output ready);
endinterface

interface bbd_cfg_if import bbd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  reg_index;
  logic [CfgDataW-1:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bbd_ram.sv -----
// ============================================================================
// bbd_ram: simple dual-port RAM
// One write port and one read port with registered read data; a read of the
// address being written returns the old contents.
// ============================================================================
`default_nettype none

module bbd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/bbd_front.sv -----
// ============================================================================
// bbd_front: input side of the demosaic
// Accepts samples and flush beats, tracks the frame position, keeps the two
// line stores and the 3x3 window, and hands masked jobs to the queue.
// ============================================================================
`default_nettype none

module bbd_front import bbd_pkg::*; #(
  parameter int unsigned MaxWidth = MaxWidthDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  bbd_in_if.sink                    in_ch,
  bbd_cfg_if.sink                   cfg_ch,
  input  wire logic [QueueCntW-1:0] q_level_i,
  output      logic                 push_o,
  output      job_t                 push_job_o
);

  localparam int unsigned ColW = $clog2(MaxWidth);
  localparam int unsigned UwW  = $clog2(MaxWidth + 1);
  localparam int unsigned CmpW = (UwW > WidthRegW) ? UwW : WidthRegW;
  localparam int unsigned LvlW = QueueCntW + 1;

  typedef struct packed {
    logic            is_raw;
    sample_t         pixel;
    logic [ColW-1:0] addr;
    logic            has_first;
    logic            has_tail;
    logic            col_lsb;
    logic            row_lsb;
    logic            top_out;
    logic            bot_out;
    logic            mask_col0;
    logic            mask_col1;
    logic            end_of_frame;
    logic            restart;
  } stage_t;

  logic [WidthRegW-1:0]  width_q;
  logic [HeightRegW-1:0] height_q;
  logic [ColW-1:0]       col_q, fcol_q;
  logic [RowCntW-1:0]    row_q;

  logic                  s1_valid_q;
  stage_t                s1_q, s1_d;

  logic                  byp_valid_q;
  logic [ColW-1:0]       byp_addr_q;
  logic [15:0]           byp_data_q;

  sample_t [2:0][2:0]    win_q, win_n, strip;

  logic [CmpW-1:0]       w_ext, uw_full;
  logic [UwW-1:0]        uw;
  logic [HeightRegW-1:0] uh;

  logic                  accept, is_raw, frame_full, raw_ok, flush_ok, work;
  logic                  emits, c_last;
  logic [ColW-1:0]       c_raw, c_fl, c;
  logic                  cfg_wr, cfg_restart;
  logic [15:0]           rdata, line;
  sample_t               up, mid;
  logic                  s1_push;

  // Clamped geometry.
  always_comb begin
    w_ext = CmpW'(width_q);
    if (w_ext == '0) begin
      uw_full = CmpW'(1);
    end else if (w_ext > CmpW'(MaxWidth)) begin
      uw_full = CmpW'(MaxWidth);
    end else begin
      uw_full = w_ext;
    end
    uw = uw_full[UwW-1:0];

    if (height_q == '0) begin
      uh = HeightRegW'(1);
    end else if (height_q > HeightMax) begin
      uh = HeightMax;
    end else begin
      uh = height_q;
    end
  end

  assign s1_push      = s1_valid_q && (s1_q.has_first || s1_q.has_tail);
  assign in_ch.ready  = (LvlW'(q_level_i) + LvlW'(s1_push)) < LvlW'(QueueDepth);
  assign cfg_ch.ready = 1'b1;

  assign accept     = in_ch.valid && in_ch.ready;
  assign is_raw     = (in_ch.operation == OP_PIXEL);
  assign frame_full = (row_q >= RowCntW'(uh));
  assign raw_ok     = accept && is_raw && !frame_full;
  assign flush_ok   = accept && !is_raw && frame_full;
  assign work       = raw_ok || flush_ok;

  assign c_raw  = (UwW'(col_q) >= uw) ? '0 : col_q;
  assign c_fl   = (UwW'(fcol_q) >= uw) ? '0 : fcol_q;
  assign c      = is_raw ? c_raw : c_fl;
  assign c_last = ((UwW'(c) + UwW'(1)) == uw);
  // Raw samples of the top row only fill the line stores.
  assign emits  = is_raw ? (row_q != '0) : 1'b1;

  assign cfg_wr      = cfg_ch.valid && cfg_ch.ready;
  assign cfg_restart = cfg_wr && ((cfg_ch.reg_index == CFG_IMAGE_WIDTH) ||
                                  (cfg_ch.reg_index == CFG_IMAGE_HEIGHT));

  always_comb begin
    s1_d              = s1_q;
    s1_d.is_raw       = is_raw;
    s1_d.pixel        = in_ch.pixel_value;
    s1_d.addr         = c;
    s1_d.has_first    = emits && (c != '0);
    s1_d.has_tail     = emits && c_last;
    s1_d.col_lsb      = c[0];
    s1_d.row_lsb      = is_raw ? ~row_q[0] : ~uh[0];
    s1_d.top_out      = is_raw ? (row_q == RowCntW'(1)) : (uh == HeightRegW'(1));
    s1_d.bot_out      = !is_raw;
    s1_d.mask_col0    = (c == ColW'(1));
    s1_d.mask_col1    = (c == '0);
    s1_d.end_of_frame = !is_raw && c_last;
    s1_d.restart      = !is_raw && c_last;
  end

  // Registers and frame position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= WidthReset;
      height_q    <= HeightReset;
      col_q       <= '0;
      fcol_q      <= '0;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      byp_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= work;
      byp_valid_q <= s1_valid_q && s1_q.is_raw;
      if (cfg_restart) begin
        if (cfg_ch.reg_index == CFG_IMAGE_WIDTH) begin
          width_q <= cfg_ch.wr_data[WidthRegW-1:0];
        end else begin
          height_q <= cfg_ch.wr_data[HeightRegW-1:0];
        end
        col_q  <= '0;
        fcol_q <= '0;
        row_q  <= '0;
      end else if (raw_ok) begin
        if (c_last) begin
          col_q <= '0;
          row_q <= row_q + RowCntW'(1);
        end else begin
          col_q <= c + ColW'(1);
        end
      end else if (flush_ok) begin
        if (c_last) begin
          col_q  <= '0;
          fcol_q <= '0;
          row_q  <= '0;
        end else begin
          fcol_q <= c + ColW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (work) begin
      s1_q <= s1_d;
    end
    byp_addr_q <= s1_q.addr;
    byp_data_q <= {mid, s1_q.pixel};
  end

  // Upper line in the high byte, middle line in the low byte.
  bbd_ram #(
    .Width (16),
    .Depth (MaxWidth)
  ) u_lines (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q && s1_q.is_raw),
    .waddr_i (s1_q.addr),
    .wdata_i ({mid, s1_q.pixel}),
    .raddr_i (c),
    .rdata_o (rdata)
  );

  // With a single-pixel row the same entry is read while the previous beat
  // writes it, so the freshly written pair is forwarded.
  assign line = (byp_valid_q && (byp_addr_q == s1_q.addr)) ? byp_data_q : rdata;
  assign up   = line[15:8];
  assign mid  = line[7:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_n[i][0] = win_q[i][1];
      win_n[i][1] = win_q[i][2];
    end
    win_n[0][2] = up;
    win_n[1][2] = mid;
    win_n[2][2] = s1_q.is_raw ? s1_q.pixel : 8'd0;

    // Neighbours outside the image read as zero.
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (((i == 0) && s1_q.top_out) || ((i == 2) && s1_q.bot_out) ||
            ((j == 0) && s1_q.mask_col0) || ((j == 1) && s1_q.mask_col1)) begin
          strip[i][j] = 8'd0;
        end else begin
          strip[i][j] = win_n[i][j];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (cfg_restart) begin
      win_q <= '0;
    end else if (s1_valid_q) begin
      win_q <= s1_q.restart ? '0 : win_n;
    end
  end

  assign push_o                  = s1_push;
  assign push_job_o.strip        = strip;
  assign push_job_o.has_first    = s1_q.has_first;
  assign push_job_o.has_tail     = s1_q.has_tail;
  assign push_job_o.col_lsb      = s1_q.col_lsb;
  assign push_job_o.row_lsb      = s1_q.row_lsb;
  assign push_job_o.end_of_frame = s1_q.end_of_frame;

endmodule

`default_nettype wire

// ----- hw/rtl/bbd_queue.sv -----
// ============================================================================
// bbd_queue: job queue
// A short first-in first-out buffer that decouples the front from the back.
// ============================================================================
`default_nettype none

module bbd_queue import bbd_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire job_t                 job_i,
  input  wire logic                 pop_i,
  output      job_t                 head_o,
  output      logic [QueueCntW-1:0] level_o
);

  job_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] level_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
      level_q <= level_q + QueueCntW'(push_i) - QueueCntW'(pop_i);
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign level_o = level_q;

endmodule

`default_nettype wire

// ----- hw/rtl/bbd_back.sv -----
// ============================================================================
// bbd_back: colour reconstruction
// Expands each job into one or two pixels, interpolates the missing colours
// and holds the result in the output register.
// ============================================================================
`default_nettype none

module bbd_back import bbd_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire job_t                 head_i,
  input  wire logic [QueueCntW-1:0] level_i,
  output      logic                 pop_o,
  bbd_out_if.source                 out_ch
);

  logic               tail_q;
  logic               out_valid_q;
  pixel_t             out_q, pix;
  logic               use_first, last, issue, xp;
  sample_t [2:0][2:0] nb;
  sample_t            centre;

  // The first pixel of a job uses the strip as is, the tail pixel sees it
  // shifted one column left with an empty right column.
  assign use_first = head_i.has_first && !tail_q;
  assign last      = !use_first || !head_i.has_tail;
  assign issue     = (level_i != '0) && (!out_valid_q || out_ch.ready);
  assign pop_o     = issue && last;
  assign xp        = use_first ? ~head_i.col_lsb : head_i.col_lsb;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (use_first) begin
        nb[i] = head_i.strip[i];
      end else begin
        nb[i][0] = head_i.strip[i][1];
        nb[i][1] = head_i.strip[i][2];
        nb[i][2] = 8'd0;
      end
    end
    centre = nb[1][1];

    pix.last_of_run  = last;
    pix.end_of_frame = !use_first && head_i.end_of_frame;
    if (!head_i.row_lsb) begin
      if (!xp) begin
        pix.green = centre;
        pix.red   = avg2(nb[0][1], nb[2][1]);
        pix.blue  = avg2(nb[1][0], nb[1][2]);
      end else begin
        pix.blue  = centre;
        pix.red   = avg4(nb[0][0], nb[0][2], nb[2][0], nb[2][2]);
        pix.green = avg4(nb[0][1], nb[2][1], nb[1][0], nb[1][2]);
      end
    end else begin
      if (!xp) begin
        pix.red   = centre;
        pix.green = avg4(nb[0][1], nb[2][1], nb[1][0], nb[1][2]);
        pix.blue  = avg4(nb[0][0], nb[0][2], nb[2][0], nb[2][2]);
      end else begin
        pix.green = centre;
        pix.red   = avg2(nb[1][0], nb[1][2]);
        pix.blue  = avg2(nb[0][1], nb[2][1]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (issue) begin
        tail_q      <= !last;
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      out_q <= pix;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.red          = out_q.red;
  assign out_ch.green        = out_q.green;
  assign out_ch.blue         = out_q.blue;
  assign out_ch.last_of_run  = out_q.last_of_run;
  assign out_ch.end_of_frame = out_q.end_of_frame;

endmodule

`default_nettype wire

// ----- hw/rtl/bayer_bilinear_demosaic.sv -----
// ============================================================================
// bayer_bilinear_demosaic: streaming bilinear demosaic for GBRG mosaics
// Turns raster-order 8-bit Bayer samples into RGB pixels, one row behind.
// ============================================================================
//
// Samples enter in raster order on in_ch with operation set to pixel; the
// pattern is GBRG, so green sits on even/even and odd/odd sites, blue on
// even rows at odd columns and red on odd rows at even columns. Every pixel
// leaves on out_ch with its native sample and the floor average of the
// nonzero neighbours it needs; neighbours outside the image count as zero
// and an average with no nonzero neighbour is zero. Output runs one row
// behind the input, so after the last row has been sent the user sends
// image_width flush beats to drain it; the frame then starts over. A sample
// beat at column c of row r >= 1 yields the pixel at column c-1 of row r-1,
// and the last column yields a second pixel as well; last_of_run marks the
// final pixel of each input beat and end_of_frame the bottom-right pixel.
// Samples beyond the frame and early flush beats are accepted and dropped.
// The block takes one input beat per clock when the output side keeps up;
// a beat at the end of a row yields two pixels, and a four-entry job queue
// between the input and output halves absorbs the extra one. The line store
// read is registered; after the window update the job is written to the
// queue, and each pixel is held in the output register. Both line stores
// share one dual-port RAM of MaxWidth entries of 16 bits, and no clearing
// pass is needed after reset. Writing either register restarts the frame
// and must only happen while the block is idle.
// ============================================================================
`default_nettype none

module bayer_bilinear_demosaic import bbd_pkg::*; #(
  parameter int unsigned MaxWidth = MaxWidthDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bbd_in_if.sink    in_ch,
  bbd_out_if.source out_ch,
  bbd_cfg_if.sink   cfg_ch
);

  logic                 push;
  job_t                 push_job, head;
  logic                 pop;
  logic [QueueCntW-1:0] level;

  // Front: accepts beats, tracks position, owns the line stores and window.
  bbd_front #(
    .MaxWidth (MaxWidth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .q_level_i  (level),
    .push_o     (push),
    .push_job_o (push_job)
  );

  // Jobs waiting for the output side.
  bbd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .head_o  (head),
    .level_o (level)
  );

  // Back: interpolation and the output register.
  bbd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .level_i (level),
    .pop_o   (pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

// ----- bench/bayer_bilinear_demosaic_tb.sv -----
// ============================================================================
// bayer_bilinear_demosaic_tb: self-checking regression of the GBRG demosaic
// Streams raw mosaic beats and flush beats into the block and predicts every
// RGB pixel with an independent model of the line stores and the 3x3 window.
// Each pixel that leaves the block is compared field by field with the oldest
// prediction. The sender idles and the receiver stalls at random.
// ============================================================================

module bayer_bilinear_demosaic_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bbd_pkg::*;

  // Sizing of the run. The settle time covers the three pipeline stages and
  // the four-entry job queue, twice over, for beats that produce no pixel.
  localparam int unsigned RandomBeats  = 720;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned DrainLimit   = 5000;
  localparam int unsigned ReportCap    = 40;
  localparam int unsigned LineDepth    = MaxWidthDefault;

  // Register indexes that the block does not decode; writes to them must
  // leave the frame untouched.
  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 2'd3;

  // Receiver behaviour: always ready, coin toss, ready when the tick count is a
  // multiple of three, or mostly stalled.
  typedef enum int unsigned {
    RX_OPEN,
    RX_COIN,
    RX_THIRD,
    RX_CHOKE
  } stall_mode_e;

  // A 3x3 neighbourhood, indexed [row][column]; row 0 is the upper row and
  // column 0 the left-hand one.
  typedef sample_t [2:0][2:0] patch_t;

  logic clk;
  logic rst_n;

  bbd_in_if  in_bus  ();
  bbd_out_if out_bus ();
  bbd_cfg_if cfg_bus ();

  bayer_bilinear_demosaic DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // --------------------------------------------------------------------------
  // Predictor state: registers, the two line stores, the window and the frame
  // position counters, kept exactly as the block should keep them.
  // --------------------------------------------------------------------------
  logic [WidthRegW-1:0]  width_reg;
  logic [HeightRegW-1:0] height_reg;
  sample_t               older_row  [LineDepth];
  sample_t               recent_row [LineDepth];
  patch_t                win;
  int unsigned           col_count;
  int unsigned           row_count;
  int unsigned           flush_col;

  // Pixels predicted but not yet seen on the output channel, oldest first.
  pixel_t pending_pixels [$];

  // Bookkeeping for the sender, the summary and the verdict.
  int unsigned error_count   = 0;
  int unsigned beats_used    = 0;
  int unsigned beats_dropped = 0;
  int unsigned pixels_seen   = 0;
  int unsigned frames_seen   = 0;
  int unsigned writes_done   = 0;
  int unsigned burst_left    = 0;
  int unsigned zero_pct      = 20;
  bit          sender_steady = 1'b0;
  bit          in_active     = 1'b0;
  bit          cfg_active    = 1'b0;

  stall_mode_e rx_mode = RX_OPEN;
  int unsigned rx_left = 0;
  int unsigned rx_tick = 0;

  // --------------------------------------------------------------------------
  // Clock and watchdog.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The slowest correct run stays well under a millisecond; this leaves
  // plenty of headroom.
  initial begin
    #5_000_000;
    $display("Timed out: the block stopped making progress.");
    $display("bayer_bilinear_demosaic regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor.
  // --------------------------------------------------------------------------

  // The width and height registers are used clamped to what the hardware
  // can hold.
  function automatic int unsigned used_width();
    if (width_reg == '0) return 1;
    if (width_reg > LineDepth) return LineDepth;
    return width_reg;
  endfunction

  function automatic int unsigned used_height();
    if (height_reg == '0) return 1;
    if (height_reg > HeightMax) return HeightMax;
    return height_reg;
  endfunction

  function automatic void restart_frame();
    col_count = 0;
    row_count = 0;
    flush_col = 0;
    win       = '0;
  endfunction

  // Floor average in which zero samples do not count towards the divisor.
  function automatic sample_t mean_nonzero(input sample_t a, input sample_t b,
                                           input sample_t c, input sample_t d);
    int unsigned sum;
    int unsigned cnt;
    sum = a + b + c + d;
    cnt = (a != 0) + (b != 0) + (c != 0) + (d != 0);
    if (cnt == 0) return '0;
    return sample_t'(sum / cnt);
  endfunction

  // Reconstructs the colour of the pixel at (x, y) from its neighbourhood.
  // Neighbours that fall outside the image are forced to zero first, so they
  // drop out of every average.
  function automatic pixel_t shade(input patch_t nb, input int unsigned x,
                                   input int unsigned y, input int unsigned w,
                                   input int unsigned h, input logic eof);
    patch_t  m;
    sample_t vert_avg;
    sample_t horz_avg;
    sample_t plus_avg;
    sample_t diag_avg;
    sample_t centre;
    pixel_t  px;
    bit      outside;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        outside = (i == 0 && y == 0) || (i == 2 && y + 1 >= h) ||
                  (j == 0 && x == 0) || (j == 2 && x + 1 >= w);
        m[i][j] = outside ? 8'd0 : nb[i][j];
      end
    end
    centre   = nb[1][1];
    vert_avg = mean_nonzero(m[0][1], m[2][1], 8'd0, 8'd0);
    horz_avg = mean_nonzero(m[1][0], m[1][2], 8'd0, 8'd0);
    plus_avg = mean_nonzero(m[0][1], m[2][1], m[1][0], m[1][2]);
    diag_avg = mean_nonzero(m[0][0], m[0][2], m[2][0], m[2][2]);
    if ((y % 2) == 0) begin
      if ((x % 2) == 0) begin
        // Green on a blue row: red above and below, blue left and right.
        px.green = centre;
        px.red   = vert_avg;
        px.blue  = horz_avg;
      end else begin
        px.blue  = centre;
        px.red   = diag_avg;
        px.green = plus_avg;
      end
    end else begin
      if ((x % 2) == 0) begin
        px.red   = centre;
        px.green = plus_avg;
        px.blue  = diag_avg;
      end else begin
        // Green on a red row: red left and right, blue above and below.
        px.green = centre;
        px.red   = horz_avg;
        px.blue  = vert_avg;
      end
    end
    px.last_of_run  = 1'b0;
    px.end_of_frame = eof;
    return px;
  endfunction

  // After column c has been shifted into the window, the pixel one column to
  // the left is complete; at the last column the right-hand edge pixel is
  // completed too, with an empty column standing in for its right neighbour.
  function automatic void expect_column(input int unsigned c, input int unsigned y,
                                        input int unsigned w, input int unsigned h,
                                        input logic frame_end);
    pixel_t first_px;
    pixel_t tail_px;
    patch_t tail;
    bit     has_first;
    bit     has_tail;
    has_first = (c >= 1);
    has_tail  = (c + 1 == w);
    if (has_first) first_px = shade(win, c - 1, y, w, h, 1'b0);
    if (has_tail) begin
      for (int i = 0; i < 3; i++) begin
        tail[i][0] = win[i][1];
        tail[i][1] = win[i][2];
        tail[i][2] = 8'd0;
      end
      tail_px = shade(tail, c, y, w, h, frame_end);
      tail_px.last_of_run = 1'b1;
    end else begin
      first_px.last_of_run = 1'b1;
    end
    if (has_first) pending_pixels.push_back(first_px);
    if (has_tail) pending_pixels.push_back(tail_px);
  endfunction

  function automatic void shift_window(input sample_t up, input sample_t mid,
                                       input sample_t down);
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = up;
    win[1][2] = mid;
    win[2][2] = down;
  endfunction

  // Advances the model by one accepted beat and queues the pixels it should
  // produce. Returns 0 for a beat the block is expected to drop.
  function automatic bit predict_pixels(input logic op, input sample_t value);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    w = used_width();
    h = used_height();
    if (op == OP_PIXEL) begin
      // Once the whole frame is in, further samples are dropped until the flush.
      if (row_count >= h) return 1'b0;
      if (col_count >= w) col_count = 0;
      c = col_count;
      shift_window(older_row[c], recent_row[c], value);
      older_row[c]  = recent_row[c];
      recent_row[c] = value;
      if (row_count >= 1) expect_column(c, row_count - 1, w, h, 1'b0);
      col_count = c + 1;
      if (col_count >= w) begin
        col_count = 0;
        row_count++;
      end
      return 1'b1;
    end
    // A flush only counts once the frame is complete.
    if (row_count < h) return 1'b0;
    if (flush_col >= w) flush_col = 0;
    c = flush_col;
    shift_window(older_row[c], recent_row[c], 8'd0);
    expect_column(c, h - 1, w, h, 1'b1);
    flush_col = c + 1;
    if (flush_col >= w) restart_frame();
    return 1'b1;
  endfunction

  function automatic void apply_register(input logic [CfgIdxW-1:0] idx,
                                         input logic [CfgDataW-1:0] data);
    case (idx)
      CFG_IMAGE_WIDTH: begin
        width_reg = data[WidthRegW-1:0];
        restart_frame();
      end
      CFG_IMAGE_HEIGHT: begin
        height_reg = data[HeightRegW-1:0];
        restart_frame();
      end
      default: ;
    endcase
  endfunction

  function automatic void reset_predictor();
    width_reg  = WidthReset;
    height_reg = HeightReset;
    for (int i = 0; i < LineDepth; i++) begin
      older_row[i]  = '0;
      recent_row[i] = '0;
    end
    restart_frame();
  endfunction

  // --------------------------------------------------------------------------
  // Reporting and checking.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    if (error_count < ReportCap) $display("%0t ns  MISMATCH  %s", $time, what);
    error_count++;
  endtask

  // Every pixel beat on the output is matched against the oldest prediction.
  // Outputs are sampled at the clock edge, before the block updates them.
  always @(posedge clk) begin : check_pixels
    pixel_t want;
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel r=%0d g=%0d b=%0d last=%0b eof=%0b",
                                  out_bus.red, out_bus.green, out_bus.blue,
                                  out_bus.last_of_run, out_bus.end_of_frame));
      end else begin
        want = pending_pixels.pop_front();
        pixels_seen++;
        if (want.end_of_frame) frames_seen++;
        if (out_bus.red !== want.red)
          report_mismatch($sformatf("pixel %0d red %0d, expected %0d",
                                    pixels_seen, out_bus.red, want.red));
        if (out_bus.green !== want.green)
          report_mismatch($sformatf("pixel %0d green %0d, expected %0d",
                                    pixels_seen, out_bus.green, want.green));
        if (out_bus.blue !== want.blue)
          report_mismatch($sformatf("pixel %0d blue %0d, expected %0d",
                                    pixels_seen, out_bus.blue, want.blue));
        if (out_bus.last_of_run !== want.last_of_run)
          report_mismatch($sformatf("pixel %0d last_of_run %0b, expected %0b",
                                    pixels_seen, out_bus.last_of_run, want.last_of_run));
        if (out_bus.end_of_frame !== want.end_of_frame)
          report_mismatch($sformatf("pixel %0d end_of_frame %0b, expected %0b",
                                    pixels_seen, out_bus.end_of_frame,
                                    want.end_of_frame));
      end
    end
  end

  // The receiver switches between stall patterns at random intervals, so
  // back-pressure lands on every phase of the block's work, including the
  // second pixel of a row end.
  always @(posedge clk) begin
    rx_tick++;
    if (rx_left == 0) begin
      rx_mode = stall_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(24, 160);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_OPEN:  out_bus.ready <= 1'b1;
      RX_COIN:  out_bus.ready <= 1'($urandom_range(0, 1));
      RX_THIRD: out_bus.ready <= (rx_tick % 3 == 0);
      default:  out_bus.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // --------------------------------------------------------------------------
  // Drivers. Every task starts and ends just after a rising edge.
  // --------------------------------------------------------------------------

  // Zero samples are drawn often, since they change the divisors and can
  // leave a pixel with no usable neighbour at all.
  function automatic sample_t rand_sample();
    if ($urandom_range(0, 99) < zero_pct) return 8'd0;
    if ($urandom_range(0, 9) == 0) return 8'hFF;
    return 8'($urandom_range(1, 255));
  endfunction

  // Presents one beat and waits for it to be taken. Between bursts the
  // sender drops valid for a random pause; in steady mode it never does.
  task automatic send_beat(input logic op, input sample_t value);
    in_bus.valid       <= 1'b1;
    in_bus.operation   <= op;
    in_bus.pixel_value <= value;
    in_active = 1'b1;
    @(posedge clk);
    while (in_bus.ready !== 1'b1) @(posedge clk);
    if (predict_pixels(op, value)) beats_used++;
    else beats_dropped++;
    if (!sender_steady) begin
      if (burst_left == 0) begin
        in_bus.valid <= 1'b0;
        in_active = 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic in_idle();
    if (in_active) begin
      in_bus.valid <= 1'b0;
      in_active = 1'b0;
    end
  endtask

  task automatic send_raw_run(input int unsigned count);
    repeat (count) send_beat(OP_PIXEL, rand_sample());
  endtask

  task automatic send_flush_run(input int unsigned count);
    repeat (count) send_beat(OP_FLUSH, 8'($urandom_range(0, 255)));
  endtask

  // Waits until every predicted pixel has arrived, then lets the pipeline
  // settle in case the last beats produced nothing. Missing pixels are
  // reported and forgotten so that the run can carry on.
  task automatic wait_drained();
    int unsigned waited;
    waited = 0;
    in_idle();
    while (pending_pixels.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    if (pending_pixels.size() != 0) begin
      report_mismatch($sformatf("%0d expected pixels never arrived", pending_pixels.size()));
      pending_pixels.delete();
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx,
                                input logic [CfgDataW-1:0] data);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.reg_index <= idx;
    cfg_bus.wr_data   <= data;
    cfg_active = 1'b1;
    @(posedge clk);
    while (cfg_bus.ready !== 1'b1) @(posedge clk);
    apply_register(idx, data);
    writes_done++;
  endtask

  task automatic cfg_idle();
    if (cfg_active) begin
      cfg_bus.valid <= 1'b0;
      cfg_active = 1'b0;
    end
  endtask

  // Programs a new geometry once the block has gone quiet; either write
  // restarts the frame, so the order is varied.
  task automatic set_geometry(input logic [CfgDataW-1:0] width_data,
                              input logic [CfgDataW-1:0] height_data,
                              input bit height_first);
    wait_drained();
    if (height_first) begin
      write_register(CFG_IMAGE_HEIGHT, height_data);
      write_register(CFG_IMAGE_WIDTH, width_data);
    end else begin
      write_register(CFG_IMAGE_WIDTH, width_data);
      write_register(CFG_IMAGE_HEIGHT, height_data);
    end
    cfg_idle();
  endtask

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Out of reset the block must work on a 640-wide frame: flushes before the
  // frame is complete are dropped, and a short run of samples stays within
  // the first row, so nothing comes out yet.
  task automatic check_reset_defaults();
    sender_steady = 1'b0;
    zero_pct      = 20;
    send_flush_run(2);
    send_raw_run(40);
    wait_drained();
  endtask

  // A hand-made 4x3 mosaic with saturated and zero samples, so that some
  // averages see one, two, three or four live neighbours and one sees none.
  // It also carries a flush in mid-frame, surplus samples after the last
  // row, and the full drain.
  task automatic check_directed_mosaic();
    sample_t mosaic [12];
    mosaic = '{8'd0,   8'd255, 8'd0,   8'd7,
               8'd255, 8'd0,   8'd9,   8'd0,
               8'd1,   8'd255, 8'd0,   8'd200};
    sender_steady = 1'b0;
    set_geometry(13'd4, 13'd3, 1'b0);
    send_beat(OP_FLUSH, 8'hA5);
    for (int i = 0; i < 8; i++) send_beat(OP_PIXEL, mosaic[i]);
    send_beat(OP_FLUSH, 8'h5A);
    for (int i = 8; i < 12; i++) send_beat(OP_PIXEL, mosaic[i]);
    send_beat(OP_PIXEL, 8'hFF);
    send_beat(OP_PIXEL, 8'h00);
    send_flush_run(4);
    wait_drained();
  endtask

  // Geometry at the edges of the register ranges, including values that the
  // block must clamp and data bits beyond the width register.
  task automatic check_register_extremes();
    zero_pct = 15;
    // Zero width and zero height behave as a single pixel.
    sender_steady = 1'b0;
    set_geometry(13'd0, 13'd0, 1'b0);
    repeat (2) begin
      send_raw_run(2);
      send_flush_run(1);
    end
    // Width field zero with the spare data bits set: a one-pixel column.
    set_geometry(13'h1800, 13'd5, 1'b1);
    send_raw_run(5);
    send_flush_run(1);
    // Width written all-ones is clamped to the widest line the stores can
    // hold, so a short run stays within the first row.
    sender_steady = 1'b1;
    set_geometry(13'h1FFF, 13'd1, 1'b0);
    send_raw_run(24);
    // Tallest frame, one pixel wide; the height is written all-ones, so none
    // of the rows sent reaches the bottom edge.
    sender_steady = 1'b0;
    set_geometry(13'd1, 13'h1FFF, 1'b1);
    send_raw_run(24);
    // Writes to undecoded indexes in mid-frame must not disturb the frame.
    set_geometry(13'd3, 13'd2, 1'b0);
    send_raw_run(4);
    wait_drained();
    write_register(CFG_SPARE_LO, 13'($urandom_range(0, 8191)));
    write_register(CFG_SPARE_HI, 13'h1FFF);
    cfg_idle();
    send_raw_run(2);
    send_flush_run(3);
    wait_drained();
  endtask

  // Random geometries, mostly small. Most frames are complete and drained
  // properly; the rest are cut short, mixed with stray flushes or drained
  // only in part, and the next geometry write restarts them.
  task automatic check_random_frames();
    int unsigned w;
    int unsigned h;
    int unsigned shape;
    int unsigned goal;
    goal = beats_used + RandomBeats;
    while (beats_used < goal) begin
      case ($urandom_range(0, 19))
        0:             w = $urandom_range(41, 128);
        1, 2, 3, 4, 5: w = $urandom_range(9, 40);
        default:       w = $urandom_range(1, 8);
      endcase
      if (w > 40) h = $urandom_range(1, 4);
      else if ($urandom_range(0, 9) < 7) h = $urandom_range(1, 6);
      else h = $urandom_range(7, 12);
      case ($urandom_range(0, 2))
        0:       zero_pct = 5;
        1:       zero_pct = 30;
        default: zero_pct = 70;
      endcase
      sender_steady = ($urandom_range(0, 3) == 0);
      set_geometry({2'($urandom_range(0, 3)), 11'(w)}, 13'(h), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 4) == 0) begin
        write_register($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                       13'($urandom_range(0, 8191)));
        cfg_idle();
      end
      repeat ($urandom_range(1, 3)) begin
        shape = $urandom_range(0, 9);
        if (shape < 7) begin
          if (shape == 0) send_beat(OP_FLUSH, 8'($urandom_range(0, 255)));
          send_raw_run(w * h);
          if (shape == 1) send_raw_run($urandom_range(1, 3));
          send_flush_run(w);
        end else if (shape < 9) begin
          repeat ($urandom_range(1, w * h + w)) begin
            send_beat(($urandom_range(0, 3) == 0) ? OP_FLUSH : OP_PIXEL, rand_sample());
          end
          break;
        end else begin
          send_raw_run(w * h);
          send_flush_run($urandom_range(0, w - 1));
          break;
        end
      end
    end
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Sequence of the run.
  // --------------------------------------------------------------------------
  initial begin
    in_bus.valid       <= 1'b0;
    in_bus.operation   <= OP_PIXEL;
    in_bus.pixel_value <= '0;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.reg_index  <= CFG_IMAGE_WIDTH;
    cfg_bus.wr_data    <= '0;
    rst_n              <= 1'b0;
    reset_predictor();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    check_reset_defaults();
    check_directed_mosaic();
    check_register_extremes();
    check_random_frames();

    $display("Run covered %0d accepted beats, %0d dropped beats and %0d register writes.",
             beats_used, beats_dropped, writes_done);
    $display("Checked %0d pixels across %0d completed frames; %0d mismatches found.",
             pixels_seen, frames_seen, error_count);
    if (error_count == 0) begin
      $display("bayer_bilinear_demosaic regression: pass");
    end else begin
      $display("bayer_bilinear_demosaic regression: fail");
    end
    $finish;
  end

endmodule
